@@ hdl/assert_macros.svh @@
// Assertion helpers shared by the RTL modules.
// Expanded inside a module that has clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked outside reset only.
`define BMFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked at every edge, reset included.
`define BMFD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/bmfd_pkg.sv @@
`default_nettype none

package bmfd_pkg;

  localparam int FRAME_BYTES        = 140;
  localparam int FB_AW              = $clog2(FRAME_BYTES);
  localparam int SUM_END            = 138;
  localparam int MARKER_LEN         = 4;
  localparam int MAX_CELLS          = 32;
  localparam int SEARCH_WINDOW_DEF  = 4096;
  localparam logic [23:0] MARKER_HEAD = 24'hAA55AA;
  localparam logic [7:0]  MARKER_TAIL = 8'hFF;
  localparam int UCODE_STEPS        = 17;
  localparam int STEP_W             = $clog2(UCODE_STEPS);

  typedef enum logic [4:0] {
    TAG_CELL_MV    = 5'd0,
    TAG_CURRENT    = 5'd1,
    TAG_SOC        = 5'd2,
    TAG_CAPACITY   = 5'd3,
    TAG_REMAINING  = 5'd4,
    TAG_TEMP       = 5'd5,
    TAG_CHARGE     = 5'd6,
    TAG_DISCHARGE  = 5'd7,
    TAG_BALANCER   = 5'd8,
    TAG_POWER      = 5'd9,
    TAG_MAX_IDX    = 5'd10,
    TAG_MAX_MV     = 5'd11,
    TAG_MIN_IDX    = 5'd12,
    TAG_MIN_MV     = 5'd13,
    TAG_AVG_MV     = 5'd14,
    TAG_CELL_COUNT = 5'd15,
    TAG_CHECKSUM   = 5'd16
  } tag_t;

  typedef enum logic [2:0] {
    VM_ZERO   = 3'd0,
    VM_SEXT16 = 3'd1,
    VM_SEXT32 = 3'd2,
    VM_CLAMP  = 3'd3,
    VM_SUM    = 3'd4
  } vmode_t;

  // One control word per record kind; len is byte count minus one,
  // reps is repeat count minus one with a stride of two bytes.
  typedef struct packed {
    tag_t             tag;
    logic [FB_AW-1:0] base;
    logic [1:0]       len;
    logic [4:0]       reps;
    vmode_t           vm;
    logic             last;
  } uword_t;

  typedef struct packed {
    logic        start;
    logic [15:0] checksum;
  } bmfd_ev_t;

  function automatic uword_t mk(input tag_t tag, input int base, input int len,
                                input int reps, input vmode_t vm, input logic last);
    uword_t w;
    w.tag  = tag;
    w.base = FB_AW'(base);
    w.len  = 2'(len);
    w.reps = 5'(reps);
    w.vm   = vm;
    w.last = last;
    return w;
  endfunction

  function automatic uword_t ucode(input logic [STEP_W-1:0] step);
    uword_t w;
    case (step)
      5'd0:    w = mk(TAG_CELL_MV,    6,   1, MAX_CELLS-1, VM_ZERO,   1'b0);
      5'd1:    w = mk(TAG_CURRENT,    70,  3, 0,           VM_SEXT32, 1'b0);
      5'd2:    w = mk(TAG_SOC,        74,  0, 0,           VM_ZERO,   1'b0);
      5'd3:    w = mk(TAG_CAPACITY,   75,  3, 0,           VM_ZERO,   1'b0);
      5'd4:    w = mk(TAG_REMAINING,  79,  3, 0,           VM_ZERO,   1'b0);
      5'd5:    w = mk(TAG_TEMP,       91,  1, 5,           VM_SEXT16, 1'b0);
      5'd6:    w = mk(TAG_CHARGE,     103, 0, 0,           VM_ZERO,   1'b0);
      5'd7:    w = mk(TAG_DISCHARGE,  104, 0, 0,           VM_ZERO,   1'b0);
      5'd8:    w = mk(TAG_BALANCER,   105, 0, 0,           VM_ZERO,   1'b0);
      5'd9:    w = mk(TAG_POWER,      111, 3, 0,           VM_SEXT32, 1'b0);
      5'd10:   w = mk(TAG_MAX_IDX,    115, 0, 0,           VM_ZERO,   1'b0);
      5'd11:   w = mk(TAG_MAX_MV,     116, 1, 0,           VM_ZERO,   1'b0);
      5'd12:   w = mk(TAG_MIN_IDX,    118, 0, 0,           VM_ZERO,   1'b0);
      5'd13:   w = mk(TAG_MIN_MV,     119, 1, 0,           VM_ZERO,   1'b0);
      5'd14:   w = mk(TAG_AVG_MV,     121, 1, 0,           VM_ZERO,   1'b0);
      5'd15:   w = mk(TAG_CELL_COUNT, 123, 0, 0,           VM_CLAMP,  1'b0);
      5'd16:   w = mk(TAG_CHECKSUM,   0,   0, 0,           VM_SUM,    1'b1);
      default: w = mk(TAG_CHECKSUM,   0,   0, 0,           VM_SUM,    1'b1);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

@@ hdl/bmfd_ram.sv @@
`default_nettype none

module bmfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = bmfd_pkg::FRAME_BYTES
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hdl/bmfd_hunt.sv @@
`default_nettype none
`include "assert_macros.svh"

module bmfd_hunt #(
  parameter int SEARCH_WINDOW = bmfd_pkg::SEARCH_WINDOW_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_fire,
  input  wire logic [7:0]                 in_byte,
  output logic                            ram_we,
  output logic [bmfd_pkg::FB_AW-1:0]      ram_waddr,
  output logic [7:0]                      ram_wdata,
  output bmfd_pkg::bmfd_ev_t              ev,
  output logic [31:0]                     good_frames
);

  import bmfd_pkg::*;

  localparam int CW = $clog2(SEARCH_WINDOW + 1);

  logic [23:0]      hist_r, hist_nxt;
  logic [1:0]       fill_r, fill_nxt;
  logic [CW-1:0]    scnt_r, scnt_nxt;
  logic             in_frame_r, in_frame_nxt;
  logic [FB_AW-1:0] pos_r, pos_nxt;
  logic [15:0]      sum_r, sum_nxt;
  logic [7:0]       hi_r, hi_nxt;
  logic [31:0]      good_r, good_nxt;

  logic [23:0]   hist_eff;
  logic [1:0]    fill_eff;
  logic [CW-1:0] scnt_eff;
  logic          window_full;

  assign window_full = (scnt_r >= CW'(SEARCH_WINDOW));
  assign hist_eff    = window_full ? '0 : hist_r;
  assign fill_eff    = window_full ? '0 : fill_r;
  assign scnt_eff    = window_full ? '0 : scnt_r;

  assign ram_we    = in_fire && in_frame_r;
  assign ram_waddr = pos_r;
  assign ram_wdata = in_byte;

  always_comb begin
    hist_nxt     = hist_r;
    fill_nxt     = fill_r;
    scnt_nxt     = scnt_r;
    in_frame_nxt = in_frame_r;
    pos_nxt      = pos_r;
    sum_nxt      = sum_r;
    hi_nxt       = hi_r;
    good_nxt     = good_r;
    ev.start     = 1'b0;
    ev.checksum  = sum_r;
    if (in_fire) begin
      if (!in_frame_r) begin
        scnt_nxt = scnt_eff + 1'b1;
        if (fill_eff == 2'd3 && hist_eff == MARKER_HEAD && in_byte == MARKER_TAIL) begin
          in_frame_nxt = 1'b1;
          pos_nxt      = FB_AW'(MARKER_LEN);
          sum_nxt      = '0;
          hist_nxt     = hist_eff;
          fill_nxt     = fill_eff;
        end else begin
          hist_nxt = {hist_eff[15:0], in_byte};
          fill_nxt = (fill_eff == 2'd3) ? fill_eff : fill_eff + 1'b1;
        end
      end else begin
        pos_nxt = pos_r + 1'b1;
        if (pos_r < FB_AW'(SUM_END)) begin
          sum_nxt = sum_r + {8'd0, in_byte};
        end
        if (pos_r == FB_AW'(SUM_END)) begin
          hi_nxt = in_byte;
        end
        if (pos_r == FB_AW'(FRAME_BYTES - 1)) begin
          if (sum_r == {hi_r, in_byte}) begin
            ev.start = 1'b1;
            good_nxt = good_r + 1'b1;
          end
          in_frame_nxt = 1'b0;
          hist_nxt     = '0;
          fill_nxt     = '0;
          scnt_nxt     = '0;
          pos_nxt      = '0;
          sum_nxt      = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r     <= '0;
      fill_r     <= '0;
      scnt_r     <= '0;
      in_frame_r <= 1'b0;
      pos_r      <= '0;
      sum_r      <= '0;
      good_r     <= '0;
    end else begin
      hist_r     <= hist_nxt;
      fill_r     <= fill_nxt;
      scnt_r     <= scnt_nxt;
      in_frame_r <= in_frame_nxt;
      pos_r      <= pos_nxt;
      sum_r      <= sum_nxt;
      good_r     <= good_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hi_r <= hi_nxt;
  end

  assign good_frames = good_r;

  `BMFD_ASSERT(a_pos_range, in_frame_r |-> (pos_r >= FB_AW'(MARKER_LEN)) && (pos_r < FB_AW'(FRAME_BYTES)), "frame position out of range")
  `BMFD_ASSERT(a_frame_open, $rose(in_frame_r) |-> (pos_r == FB_AW'(MARKER_LEN)) && (sum_r == 16'd0), "frame opened with stale position or sum")
  `BMFD_ASSERT(a_start_count, ev.start |=> good_r == $past(good_r) + 32'd1, "good frame not counted")

endmodule

`default_nettype wire

@@ hdl/bmfd_seq.sv @@
`default_nettype none
`include "assert_macros.svh"

module bmfd_seq (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire bmfd_pkg::bmfd_ev_t     ev,
  output logic [bmfd_pkg::FB_AW-1:0]  ram_raddr,
  input  wire logic [7:0]             ram_rdata,
  output logic                        busy,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [4:0]                  out_tag,
  output logic [4:0]                  out_index,
  output logic signed [32:0]          out_value,
  output logic                        out_last
);

  import bmfd_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_FETCH = 4'b0010,
    ST_LAST  = 4'b0100,
    ST_HOLD  = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [4:0]        rep_r, rep_nxt;
  logic [1:0]        bc_r, bc_nxt;
  logic [31:0]       acc_r, acc_nxt;
  logic [15:0]       cks_r, cks_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [4:0]        out_tag_r, out_tag_nxt;
  logic [4:0]        out_idx_r, out_idx_nxt;
  logic [32:0]       out_val_r, out_val_nxt;
  logic              out_last_r, out_last_nxt;

  uword_t      uw;
  logic [31:0] raw;
  logic [32:0] value;

  assign uw        = ucode(step_r);
  assign raw       = {acc_r[23:0], ram_rdata};
  assign ram_raddr = uw.base + {2'b00, rep_r, 1'b0} + {6'd0, bc_r};

  always_comb begin
    case (uw.vm)
      VM_ZERO:   value = {1'b0, raw};
      VM_SEXT32: value = {raw[31], raw};
      VM_SEXT16: value = {{17{raw[15]}}, raw[15:0]};
      VM_CLAMP: begin
        if (raw[7:0] == 8'd0) begin
          value = 33'd1;
        end else if (raw[7:0] > 8'(MAX_CELLS)) begin
          value = 33'(MAX_CELLS);
        end else begin
          value = {25'd0, raw[7:0]};
        end
      end
      VM_SUM:    value = {17'd0, cks_r};
      default:   value = '0;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    rep_nxt       = rep_r;
    bc_nxt        = bc_r;
    acc_nxt       = acc_r;
    cks_nxt       = cks_r;
    out_valid_nxt = out_valid_r;
    out_tag_nxt   = out_tag_r;
    out_idx_nxt   = out_idx_r;
    out_val_nxt   = out_val_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      ST_IDLE: begin
        if (ev.start) begin
          state_nxt = ST_FETCH;
          step_nxt  = '0;
          rep_nxt   = '0;
          bc_nxt    = '0;
          acc_nxt   = '0;
          cks_nxt   = ev.checksum;
        end
      end
      ST_FETCH: begin
        if (bc_r != 2'd0) begin
          acc_nxt = raw;
        end
        if (bc_r == uw.len) begin
          state_nxt = ST_LAST;
        end else begin
          bc_nxt = bc_r + 1'b1;
        end
      end
      ST_LAST: begin
        out_valid_nxt = 1'b1;
        out_tag_nxt   = uw.tag;
        out_idx_nxt   = rep_r;
        out_val_nxt   = value;
        out_last_nxt  = uw.last;
        state_nxt     = ST_HOLD;
      end
      ST_HOLD: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          bc_nxt        = '0;
          acc_nxt       = '0;
          if (rep_r != uw.reps) begin
            rep_nxt   = rep_r + 1'b1;
            state_nxt = ST_FETCH;
          end else if (uw.last) begin
            state_nxt = ST_IDLE;
          end else begin
            step_nxt  = step_r + 1'b1;
            rep_nxt   = '0;
            state_nxt = ST_FETCH;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      rep_r       <= '0;
      bc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      rep_r       <= rep_nxt;
      bc_r        <= bc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    cks_r      <= cks_nxt;
    out_tag_r  <= out_tag_nxt;
    out_idx_r  <= out_idx_nxt;
    out_val_r  <= out_val_nxt;
    out_last_r <= out_last_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_tag   = out_tag_r;
  assign out_index = out_idx_r;
  assign out_value = signed'(out_val_r);
  assign out_last  = out_last_r;

  `BMFD_ASSERT(a_start_idle, ev.start |-> state_r == ST_IDLE, "frame start while emitting")
  `BMFD_ASSERT(a_last_tag, out_valid_r && out_last_r |-> out_tag_r == TAG_CHECKSUM, "last record is not the checksum")
  `BMFD_ASSERT(a_rep_bound, state_r != ST_IDLE |-> rep_r <= uw.reps, "repeat counter past its limit")

endmodule

`default_nettype wire

@@ hdl/battery_monitor_frame_deframer.sv @@
`default_nettype none
`include "assert_macros.svh"

// Battery monitor frame deframer. Takes one received serial byte per transfer,
// hunts for the marker AA 55 AA FF (history cleared after SEARCH_WINDOW bytes
// without a marker), collects the 140-byte frame into a frame store and checks
// the 16-bit sum of bytes 4..137 against the big-endian word at byte 138. A bad
// frame yields nothing. A good frame yields 53 records (32 cell mV, current,
// SoC, capacity, remaining, 6 temperatures, MOS and balancer flags, power,
// min/max/average cell data, clamped cell count, checksum), the checksum record
// flagged last, each with the running good-frame count. While searching and
// collecting, one byte is taken every cycle. After the final byte of a good
// frame, in_ready stays low while a microcoded sequencer reads the fields one
// byte per cycle through the single read port of the frame store; each record
// is held on the output until out_ready takes it, before the next is read.
module battery_monitor_frame_deframer #(
  parameter int SEARCH_WINDOW = bmfd_pkg::SEARCH_WINDOW_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         in_rx_byte,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [4:0]              out_record_tag,
  output logic [4:0]              out_record_index,
  output logic signed [32:0]      out_record_value,
  output logic                    out_last_of_frame,
  output logic [31:0]             out_good_frames
);

  import bmfd_pkg::*;

  logic             in_fire;
  logic             busy;
  logic             ram_we;
  logic [FB_AW-1:0] ram_waddr;
  logic [7:0]       ram_wdata;
  logic [FB_AW-1:0] ram_raddr;
  logic [7:0]       ram_rdata;
  bmfd_ev_t         ev;

  assign in_ready = !busy;
  assign in_fire  = in_valid && in_ready;

  bmfd_hunt #(
    .SEARCH_WINDOW(SEARCH_WINDOW)
  ) u_hunt (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .in_byte    (in_rx_byte),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ev         (ev),
    .good_frames(out_good_frames)
  );

  bmfd_ram #(
    .WIDTH(8),
    .DEPTH(FRAME_BYTES)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  bmfd_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .ev        (ev),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .busy      (busy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_tag   (out_record_tag),
    .out_index (out_record_index),
    .out_value (out_record_value),
    .out_last  (out_last_of_frame)
  );

  `BMFD_ASSERT(a_hold_input, out_valid |-> !in_ready, "input taken while a record is pending")
  `BMFD_ASSERT(a_no_write_busy, busy |-> !ram_we, "frame store written during emission")
  `BMFD_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid && in_ready, "block not quiet after reset")

endmodule

`default_nettype wire
